### rtl/jsc_pkg.sv
// ----------------------------------------------------------------------------
// jsc_pkg
// Types, character codes and literal tables shared by the scalar checker.
// ----------------------------------------------------------------------------
package jsc_pkg;

    typedef enum logic [3:0] {
        PH_LEAD     = 4'd0,
        PH_LITERAL  = 4'd1,
        PH_SIGN     = 4'd2,
        PH_INT      = 4'd3,
        PH_ZERO     = 4'd4,
        PH_DOT      = 4'd5,
        PH_FRAC     = 4'd6,
        PH_EXP      = 4'd7,
        PH_EXPSIGN  = 4'd8,
        PH_EXPDIG   = 4'd9,
        PH_STRING   = 4'd10,
        PH_TRAIL    = 4'd11
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EXPECT     = 3'd1,
        ST_INVALID    = 3'd2,
        ST_NOT_SINGLE = 3'd3,
        ST_MISS_QUOTE = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        KIND_NULL   = 3'd0,
        KIND_FALSE  = 3'd1,
        KIND_TRUE   = 3'd2,
        KIND_NUMBER = 3'd3,
        KIND_STRING = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        LIT_NULL  = 2'd0,
        LIT_FALSE = 2'd1,
        LIT_TRUE  = 2'd2
    } t_lit;

    localparam logic ITEM_CONTENT = 1'b0;
    localparam logic ITEM_VERDICT = 1'b1;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_N  = 8'h6E;
    localparam logic [7:0] CH_LO_T  = 8'h74;

    // One step result travelling from the core to the output register
    typedef struct packed {
        logic        valid;
        logic        item_kind;
        logic [7:0]  content_byte;
        t_status     parse_status;
        t_kind       value_kind;
        logic [15:0] string_length;
    } t_step_res;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
    endfunction

    function automatic logic is_decimal(input logic [7:0] b);
        return (b >= CH_0) && (b <= CH_9);
    endfunction

    function automatic logic is_exp(input logic [7:0] b);
        return (b == CH_LO_E) || (b == CH_UP_E);
    endfunction

    function automatic logic [2:0] lit_len(input t_lit w);
        logic [2:0] len;
        case (w)
            LIT_FALSE: len = 3'd5;
            default:   len = 3'd4;
        endcase
        return len;
    endfunction

    function automatic t_kind lit_kind(input t_lit w);
        t_kind k;
        case (w)
            LIT_FALSE: k = KIND_FALSE;
            LIT_TRUE:  k = KIND_TRUE;
            default:   k = KIND_NULL;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] lit_char(input t_lit w, input logic [2:0] p);
        logic [7:0] c;
        c = 8'h00;
        case (w)
            LIT_FALSE: begin
                case (p)
                    3'd0:    c = 8'h66;
                    3'd1:    c = 8'h61;
                    3'd2:    c = 8'h6C;
                    3'd3:    c = 8'h73;
                    3'd4:    c = 8'h65;
                    default: c = 8'h00;
                endcase
            end
            LIT_TRUE: begin
                case (p)
                    3'd0:    c = 8'h74;
                    3'd1:    c = 8'h72;
                    3'd2:    c = 8'h75;
                    3'd3:    c = 8'h65;
                    default: c = 8'h00;
                endcase
            end
            default: begin
                case (p)
                    3'd0:    c = 8'h6E;
                    3'd1:    c = 8'h75;
                    3'd2:    c = 8'h6C;
                    3'd3:    c = 8'h6C;
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

### rtl/jsc_if.sv
// ----------------------------------------------------------------------------
// jsc_if
// Valid/ready channels for text words in and result words out.
// ----------------------------------------------------------------------------
interface jsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface jsc_out_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [7:0]  content_byte;
    logic [2:0]  parse_status;
    logic [2:0]  value_kind;
    logic [15:0] string_length;

    modport source (output valid, output item_kind, output content_byte,
                    output parse_status, output value_kind, output string_length,
                    input ready);
    modport sink   (input valid, input item_kind, input content_byte,
                    input parse_status, input value_kind, input string_length,
                    output ready);
endinterface

### rtl/jsc_in_reg.sv
// ----------------------------------------------------------------------------
// jsc_in_reg
// Input register: captures one text word and holds it until the core takes it.
// ----------------------------------------------------------------------------
module jsc_in_reg
    import jsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    jsc_in_if.sink     i_in,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_text_byte,
    output logic       o_end
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_end;
    logic       w_take;

    assign i_in.ready = !r_valid || i_advance;
    assign w_take     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte <= i_in.text_byte;
            r_end  <= i_in.end_of_text;
        end
    end

    assign o_valid     = r_valid;
    assign o_text_byte = r_byte;
    assign o_end       = r_end;

endmodule

### rtl/jsc_core.sv
// ----------------------------------------------------------------------------
// jsc_core
// Scanner state and the per-word step: one text word in, at most one result.
// ----------------------------------------------------------------------------
module jsc_core
    import jsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_text_byte,
    input  logic       i_end,
    output t_step_res  o_res
);

    t_phase      r_phase,  n_phase;
    logic [2:0]  r_pos,    n_pos;
    t_lit        r_which,  n_which;
    t_status     r_status, n_status;
    t_kind       r_kind,   n_kind;
    logic [15:0] r_count,  n_count;

    t_status     w_vstat;
    t_kind       w_vkind;
    logic [2:0]  w_pos_inc;
    logic        w_lit_hit;
    logic [7:0]  b;

    assign b         = i_text_byte;
    assign w_pos_inc = r_pos + 3'd1;
    assign w_lit_hit = (r_pos < lit_len(r_which)) && (b == lit_char(r_which, r_pos));

    // Verdict for an end marker
    always_comb begin
        w_vstat = r_status;
        w_vkind = r_kind;
        if (r_status == ST_OK) begin
            unique case (r_phase)
                PH_LEAD:   w_vstat = ST_EXPECT;
                PH_STRING: w_vstat = ST_MISS_QUOTE;
                PH_INT, PH_ZERO, PH_FRAC, PH_EXPDIG: w_vkind = KIND_NUMBER;
                PH_TRAIL:  w_vstat = ST_OK;
                default:   w_vstat = ST_INVALID;
            endcase
        end
        if (w_vstat != ST_OK) begin
            w_vkind = KIND_NULL;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_which  = r_which;
        n_status = r_status;
        n_kind   = r_kind;
        n_count  = r_count;

        o_res               = '0;
        o_res.parse_status  = ST_OK;
        o_res.value_kind    = KIND_NULL;

        if (i_end) begin
            o_res.valid         = 1'b1;
            o_res.item_kind     = ITEM_VERDICT;
            o_res.parse_status  = w_vstat;
            o_res.value_kind    = w_vkind;
            o_res.string_length = (w_vstat == ST_OK && w_vkind == KIND_STRING) ? r_count : '0;
            n_phase  = PH_LEAD;
            n_pos    = '0;
            n_which  = LIT_NULL;
            n_status = ST_OK;
            n_kind   = KIND_NULL;
            n_count  = '0;
        end else if (r_status == ST_OK) begin
            unique case (r_phase)
                PH_LEAD: begin
                    if (is_space(b)) begin
                        n_phase = PH_LEAD;
                    end else if (b == CH_LO_N || b == CH_LO_F || b == CH_LO_T) begin
                        n_which = (b == CH_LO_N) ? LIT_NULL :
                                  (b == CH_LO_F) ? LIT_FALSE : LIT_TRUE;
                        n_pos   = 3'd1;
                        n_phase = PH_LITERAL;
                    end else if (b == CH_QUOTE) begin
                        n_count = '0;
                        n_phase = PH_STRING;
                    end else if (b == CH_MINUS) begin
                        n_phase = PH_SIGN;
                    end else if (b == CH_0) begin
                        n_phase = PH_ZERO;
                    end else if (b >= CH_1 && b <= CH_9) begin
                        n_phase = PH_INT;
                    end else begin
                        n_status = ST_INVALID;
                        n_kind   = KIND_NULL;
                    end
                end
                PH_LITERAL: begin
                    if (w_lit_hit) begin
                        n_pos = w_pos_inc;
                        if (w_pos_inc >= lit_len(r_which)) begin
                            n_kind  = lit_kind(r_which);
                            n_phase = PH_TRAIL;
                        end
                    end else begin
                        n_status = ST_INVALID;
                        n_kind   = KIND_NULL;
                    end
                end
                PH_SIGN: begin
                    if (b == CH_0) begin
                        n_phase = PH_ZERO;
                    end else if (b >= CH_1 && b <= CH_9) begin
                        n_phase = PH_INT;
                    end else begin
                        n_status = ST_INVALID;
                        n_kind   = KIND_NULL;
                    end
                end
                PH_INT, PH_ZERO, PH_FRAC: begin
                    if (is_decimal(b) && r_phase != PH_ZERO) begin
                        n_phase = r_phase;
                    end else if (b == CH_DOT && r_phase != PH_FRAC) begin
                        n_phase = PH_DOT;
                    end else if (is_exp(b)) begin
                        n_phase = PH_EXP;
                    end else if (is_space(b)) begin
                        n_kind  = KIND_NUMBER;
                        n_phase = PH_TRAIL;
                    end else begin
                        n_status = ST_NOT_SINGLE;
                        n_kind   = KIND_NULL;
                    end
                end
                PH_DOT, PH_EXPSIGN: begin
                    if (is_decimal(b)) begin
                        n_phase = (r_phase == PH_DOT) ? PH_FRAC : PH_EXPDIG;
                    end else begin
                        n_status = ST_INVALID;
                        n_kind   = KIND_NULL;
                    end
                end
                PH_EXP: begin
                    if (b == CH_PLUS || b == CH_MINUS) begin
                        n_phase = PH_EXPSIGN;
                    end else if (is_decimal(b)) begin
                        n_phase = PH_EXPDIG;
                    end else begin
                        n_status = ST_INVALID;
                        n_kind   = KIND_NULL;
                    end
                end
                PH_EXPDIG: begin
                    if (is_decimal(b)) begin
                        n_phase = PH_EXPDIG;
                    end else if (is_space(b)) begin
                        n_kind  = KIND_NUMBER;
                        n_phase = PH_TRAIL;
                    end else begin
                        n_status = ST_NOT_SINGLE;
                        n_kind   = KIND_NULL;
                    end
                end
                PH_STRING: begin
                    if (b == CH_QUOTE) begin
                        n_kind  = KIND_STRING;
                        n_phase = PH_TRAIL;
                    end else begin
                        if (r_count != LEN_MAX) begin
                            n_count = r_count + 16'd1;
                        end
                        o_res.valid        = 1'b1;
                        o_res.item_kind    = ITEM_CONTENT;
                        o_res.content_byte = b;
                    end
                end
                PH_TRAIL: begin
                    if (!is_space(b)) begin
                        n_status = ST_NOT_SINGLE;
                        n_kind   = KIND_NULL;
                    end
                end
                default: begin
                    n_status = ST_INVALID;
                    n_kind   = KIND_NULL;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LEAD;
            r_pos    <= '0;
            r_which  <= LIT_NULL;
            r_status <= ST_OK;
            r_kind   <= KIND_NULL;
            r_count  <= '0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_which  <= n_which;
            r_status <= n_status;
            r_kind   <= n_kind;
            r_count  <= n_count;
        end
    end

    a_content_in_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.item_kind == ITEM_CONTENT) |-> (r_phase == PH_STRING && !i_end))
        else $error("content word produced outside a string");

    a_verdict_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_end) |=> (r_phase == PH_LEAD && r_status == ST_OK && r_count == 16'd0))
        else $error("state not cleared after verdict");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !i_end && r_status != ST_OK) |=> (r_status == $past(r_status)))
        else $error("error status changed before end marker");

    a_ok_kind_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.item_kind == ITEM_VERDICT && o_res.parse_status != ST_OK)
        |-> (o_res.value_kind == KIND_NULL && o_res.string_length == 16'd0))
        else $error("failed verdict carries a value kind or length");

endmodule

### rtl/jsc_out_reg.sv
// ----------------------------------------------------------------------------
// jsc_out_reg
// Result register: holds a result word until the receiver takes it.
// ----------------------------------------------------------------------------
module jsc_out_reg
    import jsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  t_step_res  i_res,
    output logic       o_free,
    jsc_out_if.source  o_out
);

    logic      r_valid;
    t_step_res r_res;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_fire && i_res.valid;
        end
    end

    // load only when a word is produced
    always_ff @(posedge i_clk) begin
        if (o_free && i_fire && i_res.valid) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.item_kind     = r_res.item_kind;
    assign o_out.content_byte  = r_res.content_byte;
    assign o_out.parse_status  = r_res.parse_status;
    assign o_out.value_kind    = r_res.value_kind;
    assign o_out.string_length = r_res.string_length;

endmodule

### rtl/json_scalar_token_checker_unit.sv
// ----------------------------------------------------------------------------
// json_scalar_token_checker_unit
// Checks that a byte stream holds one JSON scalar and reports a verdict.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one text word per handshake: a byte, or an end marker when
//   end_of_text is set. o_out carries result words: each string content
//   byte as it arrives (item_kind 0), and one verdict per end marker
//   (item_kind 1) with status, value kind and string length.
//   A word sits in the input register and is stepped through the scanner
//   state once the result register is free; any result that it yields
//   lands in the result register and is offered on o_out from there.
//   One word per cycle is sustained while o_out does not stall; the single
//   scanner state update per word sets that rate.
//   When o_out stalls, the held result stays put and the input register
//   fills; i_in.ready drops only when both are occupied.
//   Reset (i_rst_n low, synchronous) empties both registers and returns the
//   scanner to the leading-whitespace state with ok status. After every
//   verdict the scanner returns to that state on its own.
// ----------------------------------------------------------------------------
module json_scalar_token_checker_unit
    import jsc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    jsc_in_if.sink    i_in,
    jsc_out_if.source o_out
);

    logic       w_in_valid;
    logic [7:0] w_in_byte;
    logic       w_in_end;
    logic       w_out_free;
    logic       w_fire;
    t_step_res  w_res;

    // advance the held word whenever the result slot can take its outcome
    assign w_fire = w_in_valid && w_out_free;

    jsc_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_advance   (w_fire),
        .o_valid     (w_in_valid),
        .o_text_byte (w_in_byte),
        .o_end       (w_in_end)
    );

    jsc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_text_byte (w_in_byte),
        .i_end       (w_in_end),
        .o_res       (w_res)
    );

    jsc_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_res   (w_res),
        .o_free  (w_out_free),
        .o_out   (o_out)
    );

endmodule
